>>> hw/rtl/edf_pkg.sv
// Shared types and constants for the EDF priority scheduler.
package edf_pkg;

    typedef enum logic [1:0] {
        CMD_REGISTER   = 2'd0,
        CMD_UPDATE     = 2'd1,
        CMD_UNREGISTER = 2'd2,
        CMD_SCHEDULE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    localparam int TASK_W     = 16;
    localparam int TICK_W     = 32;
    localparam int PRIO_W     = 5;
    localparam int MAXPRIO_W  = 6;
    localparam int RANK_OFFSET = 2;
    localparam logic [PRIO_W-1:0] PRIO_TOP = 5'd31;
    localparam logic [MAXPRIO_W-1:0] MAXPRIO_RESET = 6'd5;

    // one table row
    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [TICK_W-1:0] deadline;
        logic [TICK_W-1:0] period;
        logic [PRIO_W-1:0] base_prio;
    } entry_t;

    // one result
    typedef struct packed {
        logic                 last;
        logic [1:0]           status;
        logic [PRIO_W-1:0]    prio;
        logic [TASK_W-1:0]    task_id;
    } result_t;

endpackage

>>> hw/rtl/edf_prio_calc.sv
// Scheduled priority from rank, max_priority and base priority.
module edf_prio_calc
    import edf_pkg::*;
#(
    parameter int RANK_W = 4
)
(
    input  logic [MAXPRIO_W-1:0] max_priority,
    input  logic [RANK_W-1:0]    rank,
    input  logic [PRIO_W-1:0]    base_prio,
    output logic [PRIO_W-1:0]    prio
);
    localparam int SW = (RANK_W > MAXPRIO_W ? RANK_W : MAXPRIO_W) + 2;

    logic [SW-1:0] need;
    logic [SW-1:0] mp;
    logic [SW-1:0] diff;
    logic [SW-1:0] raised;

    always_comb
    begin
        need   = SW'(rank) + SW'(RANK_OFFSET);
        mp     = SW'(max_priority);
        diff   = (mp >= need) ? (mp - need) : '0;
        raised = (diff < SW'(base_prio)) ? SW'(base_prio) : diff;
        prio   = (raised > SW'(PRIO_TOP)) ? PRIO_TOP : raised[PRIO_W-1:0];
    end
endmodule

>>> hw/rtl/edf_priority_scheduler_unit.sv
// Top level of the EDF priority scheduler.
// Usage: one request enters on s_axis. s_axis_tuser carries command[1:0];
// s_axis_tdata packs task_id, now_tick, rel_deadline, task_period,
// base_priority from bit 0 up. Results leave on m_axis: tdata =
// out_task[15:0], out_priority[20:16]; tuser = status[1:0]; tlast marks the
// final result of the request. max_priority is written on cfg_we/cfg_wdata.
// The table sits in one memory array with a single read port and one
// write port; a sequencer walks it entry by entry, and one 32-bit
// comparator orders deadlines for the sort.
// Register writes the new entry, then emits its result; update/unregister
// run a linear search, and unregister a compaction walk; schedule runs a
// bubble sort of N*(N-1)/2 compares, each a read/compare step with a
// write-back step when it swaps, then emits one result per sorted entry.
// The single memory port sets the pace of each step.
// s_axis_tready is high only in idle; one request is worked at a time.
// A result waiting in the output register does not block the next request.
// When the receiver stalls, the result holds in the output register and
// the sequencer waits. Reset empties the table (count to zero) and sets
// max_priority to 5; table contents are not cleared.
module edf_priority_scheduler_unit
    import edf_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,     // max_priority[5:0]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,  // task_id, now, rel, period, base
    input  logic [1:0]   s_axis_tuser,  // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,  // out_task, out_priority
    output logic [1:0]   m_axis_tuser,  // status
    output logic         m_axis_tlast
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_REG, S_FRD, S_FCMP, S_SHRD, S_SHWR, S_UPD,
        S_SRD0, S_SRD1, S_SCMP, S_SWB, S_ORD, S_OOUT, S_EMIT, S_WAIT
    } state_t;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_reg;          // registered read data
    entry_t hold_reg;        // first operand of a compare
    logic [IW-1:0] raddr;
    logic          rd_en;
    logic          we;
    logic [IW-1:0] waddr;
    entry_t        wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (rd_en)
            rd_reg <= mem[raddr];
    end

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [MAXPRIO_W-1:0] maxp_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] lim_reg;
    logic [1:0]  cmd_reg;
    logic [TASK_W-1:0] id_reg;
    logic [TICK_W-1:0] now_reg;
    logic [TICK_W-1:0] rel_reg;
    logic [TICK_W-1:0] per_reg;
    logic [PRIO_W-1:0] bp_reg;
    result_t res_reg;        // output register
    result_t wres_reg;       // single result under construction
    logic    ovalid_reg;
    logic [PRIO_W-1:0] calc_prio;
    result_t start_res;
    state_t  start_state;
    result_t sched_res;
    logic    out_load;

    edf_prio_calc #(.RANK_W(CW)) u_calc (
        .max_priority(maxp_reg),
        .rank(i_reg),
        .base_prio(rd_reg.base_prio),
        .prio(calc_prio)
    );

    // compares the held entry's deadline against the table entry's
    logic [TICK_W-1:0] cmp_a, cmp_b;
    logic cmp_gt;
    assign cmp_gt = cmp_a > cmp_b;
    always_comb
    begin
        cmp_a = hold_reg.deadline;
        cmp_b = rd_reg.deadline;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {3'b000, res_reg.prio, res_reg.task_id};
    assign m_axis_tuser  = res_reg.status;
    assign m_axis_tlast  = res_reg.last;

    // output register takes a new result when empty or being drained
    assign out_load = ((state_reg == S_OOUT) || (state_reg == S_EMIT)) &&
                      (!ovalid_reg || m_axis_tready);

    // first result and next state for an incoming request
    always_comb
    begin
        start_res   = '{last: 1'b1, status: ST_OK, prio: '0,
                        task_id: s_axis_tdata[15:0]};
        start_state = S_IDLE;
        case (cmd_t'(s_axis_tuser))
            CMD_REGISTER:
                if (count_reg == CW'(TABLE_DEPTH))
                begin
                    start_res.status = ST_FULL;
                    start_state = S_EMIT;
                end
                else
                    start_state = S_REG;
            CMD_UPDATE, CMD_UNREGISTER:
                if (count_reg == '0)
                begin
                    start_res.status = ST_NOT_FOUND;
                    start_state = S_EMIT;
                end
                else
                    start_state = S_FRD;
            default:
                if (count_reg == '0)
                begin
                    start_res.task_id = '0;
                    start_res.status = ST_NOT_FOUND;
                    start_state = S_EMIT;
                end
                else if (count_reg == CW'(1))
                    start_state = S_ORD;
                else
                    start_state = S_SRD0;
        endcase
    end

    // one scheduled result per sorted entry
    always_comb
    begin
        sched_res = '{last: (i_reg + CW'(1) == count_reg), status: ST_OK,
                      prio: calc_prio, task_id: rd_reg.task_id};
    end

    always_comb
    begin
        rd_en = 1'b0;
        raddr = i_reg[IW-1:0];
        we    = 1'b0;
        waddr = i_reg[IW-1:0];
        wdata = rd_reg;
        case (state_reg)
            S_REG:
            begin
                we = 1'b1;
                waddr = count_reg[IW-1:0];
                wdata = '{task_id: id_reg, deadline: now_reg + rel_reg,
                          period: per_reg, base_prio: bp_reg};
            end
            S_FRD, S_SHRD, S_SRD0, S_ORD: rd_en = 1'b1;
            S_SRD1:
            begin
                rd_en = 1'b1;
                raddr = IW'(i_reg + CW'(1));
            end
            S_SHWR:
            begin
                we = 1'b1;
                waddr = IW'(i_reg - CW'(1));
            end
            S_UPD:
            begin
                we = 1'b1;
                wdata.deadline = now_reg + rd_reg.period;
            end
            S_SCMP:
            begin
                we = cmp_gt;
                wdata = rd_reg;
            end
            S_SWB:
            begin
                we = 1'b1;
                waddr = IW'(i_reg + CW'(1));
                wdata = hold_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            maxp_reg   <= MAXPRIO_RESET;
            ovalid_reg <= 1'b0;
            i_reg      <= '0;
            lim_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                maxp_reg <= cfg_wdata[MAXPRIO_W-1:0];
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
            if (out_load)
                res_reg <= (state_reg == S_OOUT) ? sched_res : wres_reg;
            case (state_reg)
                S_IDLE:
                    if (s_axis_tvalid)
                    begin
                        cmd_reg  <= s_axis_tuser;
                        id_reg   <= s_axis_tdata[15:0];
                        now_reg  <= s_axis_tdata[47:16];
                        rel_reg  <= s_axis_tdata[79:48];
                        per_reg  <= s_axis_tdata[111:80];
                        bp_reg   <= s_axis_tdata[116:112];
                        i_reg    <= '0;
                        lim_reg  <= count_reg - CW'(1);
                        wres_reg <= start_res;
                        state_reg <= start_state;
                    end
                S_REG:
                begin
                    count_reg <= count_reg + CW'(1);
                    wres_reg.prio <= bp_reg;
                    state_reg <= S_EMIT;
                end
                S_FRD: state_reg <= S_FCMP;
                S_FCMP:
                    if (rd_reg.task_id == id_reg)
                    begin
                        if (cmd_reg == CMD_UPDATE)
                        begin
                            if (rd_reg.period == '0)
                            begin
                                wres_reg.status <= ST_NOT_FOUND;
                                state_reg <= S_EMIT;
                            end
                            else
                                state_reg <= S_UPD;
                        end
                        else
                        begin
                            wres_reg.prio <= rd_reg.base_prio;
                            i_reg <= i_reg + CW'(1);
                            state_reg <= S_SHRD;
                        end
                    end
                    else if (i_reg + CW'(1) == count_reg)
                    begin
                        wres_reg.status <= ST_NOT_FOUND;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        i_reg <= i_reg + CW'(1);
                        state_reg <= S_FRD;
                    end
                S_UPD: state_reg <= S_EMIT;
                S_SHRD:
                    if (i_reg == count_reg)
                    begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_SHWR;
                S_SHWR:
                begin
                    i_reg <= i_reg + CW'(1);
                    state_reg <= S_SHRD;
                end
                S_SRD0: state_reg <= S_SRD1;
                S_SRD1:
                begin
                    hold_reg <= rd_reg;
                    state_reg <= S_SCMP;
                end
                S_SCMP:
                    if (cmp_gt)
                        state_reg <= S_SWB;
                    else
                        state_reg <= S_WAIT;
                S_SWB: state_reg <= S_WAIT;
                S_WAIT:
                    // advance bubble index
                    if (i_reg + CW'(1) >= lim_reg)
                    begin
                        i_reg <= '0;
                        if (lim_reg == CW'(1))
                            state_reg <= S_ORD;
                        else
                        begin
                            lim_reg <= lim_reg - CW'(1);
                            state_reg <= S_SRD0;
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + CW'(1);
                        state_reg <= S_SRD0;
                    end
                S_ORD: state_reg <= S_OOUT;
                S_OOUT:
                    if (out_load)
                    begin
                        if (i_reg + CW'(1) == count_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            i_reg <= i_reg + CW'(1);
                            state_reg <= S_ORD;
                        end
                    end
                S_EMIT:
                    if (out_load)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
